[rtl/i2ctrf_pkg.sv]
`timescale 1ns / 1ps

package i2ctrf_pkg;

  // bus protocol phases of the target
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_HIGH,
    PH_START,
    PH_ADDR_H,
    PH_ADDR_L,
    PH_ACK1_H,
    PH_ACK1_L,
    PH_REG_H,
    PH_REG_L,
    PH_NACK_H,
    PH_NACK_L,
    PH_ACK2_H,
    PH_ACK2_L,
    PH_D1_H,
    PH_D1_L_ONE,
    PH_D1_L_ZERO,
    PH_RS_WAIT,
    PH_DATA_H,
    PH_DATA_L,
    PH_ACK3_H,
    PH_ACK3_L,
    PH_RACK_H,
    PH_RACK_L,
    PH_TX_H,
    PH_TX_L,
    PH_MACK_H,
    PH_MACK_L
  } phase_e;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned IndexW   = 3;
  localparam logic [7:0]  MsbMask  = 8'h80;

  // one sample of the two bus lines
  typedef struct packed {
    logic sda;
    logic scl;
  } line_sample_t;

  // one result, packed lowest field last
  typedef struct packed {
    logic              busy;
    logic [7:0]        store_value;
    logic [IndexW-1:0] store_index;
    logic              store_strobe;
    logic              sda_pull_low;
  } result_t;

endpackage

[rtl/i2c_target_register_file.sv]
`timescale 1ns / 1ps

// I2C target with a small register file. Each request carries one sample of
// SCL and SDA; each response carries the open-drain SDA drive after that
// sample, a store strobe with index and byte, and a busy flag. The block takes
// one sample per clock unless the output stalls: a two-entry queue sits in
// front of the protocol engine and a result register behind it, so an
// accepted sample passes through the queue, then the engine step into the
// result register. Register entries that were never written read back as
// their own index through per-entry written flags, so no clearing pass
// follows reset.
module i2c_target_register_file #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,     // own_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // scl_level, sda_level, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // sda_pull_low, store_strobe,
                                       // store_index[2:0], store_value[7:0],
                                       // busy_res, zero fill
);

  logic [6:0]                own_address_q;
  i2ctrf_pkg::line_sample_t  in_sample;
  i2ctrf_pkg::line_sample_t  q_sample;
  logic                      q_valid, q_ready;
  i2ctrf_pkg::result_t       res;

  // own address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= 7'd32;
    end else if (cfg_we_i) begin
      own_address_q <= cfg_wdata_i;
    end
  end

  assign in_sample.scl = s_axis_tdata[0];
  assign in_sample.sda = s_axis_tdata[1];

  // sample queue
  i2ctrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  (in_sample),
    .out_valid_o  (q_valid),
    .out_ready_i  (q_ready),
    .out_sample_o (q_sample)
  );

  // protocol engine and register file
  i2ctrf_engine #(
    .NUM_REGS (NUM_REGS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .own_address_i (own_address_q),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_sample_i   (q_sample),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (res)
  );

  assign m_axis_tdata = {2'b00, res};

  // a stored byte is always inside a transaction and acked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.store_strobe) |-> (res.busy && res.sda_pull_low))
    else $error("store strobe outside an acked transaction");

  // the queue only fills up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready && $past(s_axis_tready)) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("sample queue filled without an output stall");

  // the engine never advances while its result register is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !q_ready)
    else $error("engine stepped over a stalled result");

endmodule

[rtl/i2ctrf_front.sv]
`timescale 1ns / 1ps

module i2ctrf_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i2ctrf_pkg::line_sample_t in_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i2ctrf_pkg::line_sample_t out_sample_o
);

  localparam int unsigned Depth = 2;

  i2ctrf_pkg::line_sample_t   buf_q [Depth];
  logic                       wr_ptr_q, wr_ptr_d;
  logic                       rd_ptr_q, rd_ptr_d;
  logic [1:0]                 count_q, count_d;
  logic                       push, pop;

  // handshakes on both sides of the queue
  assign in_ready_o   = (count_q != 2'(Depth));
  assign out_valid_o  = (count_q != 2'd0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = out_valid_o && out_ready_i;
  assign out_sample_o = buf_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // sample storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_sample_i;
    end
  end

endmodule

[rtl/i2ctrf_engine.sv]
`timescale 1ns / 1ps

module i2ctrf_engine #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [6:0]               own_address_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  i2ctrf_pkg::line_sample_t in_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output i2ctrf_pkg::result_t      out_res_o
);

  localparam int unsigned PtrW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  i2ctrf_pkg::phase_e                   phase_q, phase_d;
  logic [i2ctrf_pkg::ByteBits-1:0]      shift_q, shift_d;
  logic [i2ctrf_pkg::BitCntW-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [PtrW-1:0]                      ptr_q, ptr_d;
  logic                                 wr_en;
  logic                                 step;
  logic                                 out_valid_q;
  i2ctrf_pkg::result_t                  res_q, res_d;
  logic [NUM_REGS-1:0]                  vld_q;
  logic [i2ctrf_pkg::ByteBits-1:0]      mem_q [NUM_REGS];
  logic [i2ctrf_pkg::ByteBits-1:0]      rd_q;
  logic [i2ctrf_pkg::ByteBits-1:0]      waddr, raddr;
  logic                                 scl, sda;

  assign scl     = in_sample_i.scl;
  assign sda     = in_sample_i.sda;
  assign waddr   = {own_address_i, 1'b0};
  assign raddr   = {own_address_i, 1'b1};
  assign cnt_inc = cnt_q + 4'd1;

  // one sample per cycle unless the result register is stalled
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // next state of the protocol machine
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    wr_en   = 1'b0;
    case (phase_q)
      i2ctrf_pkg::PH_IDLE: begin
        if (scl && sda) phase_d = i2ctrf_pkg::PH_HIGH;
      end
      i2ctrf_pkg::PH_HIGH: begin
        if (!scl) phase_d = i2ctrf_pkg::PH_IDLE;
        else if (!sda) phase_d = i2ctrf_pkg::PH_START;
      end
      i2ctrf_pkg::PH_START: begin
        if (sda) begin
          phase_d = scl ? i2ctrf_pkg::PH_HIGH : i2ctrf_pkg::PH_IDLE;
        end else if (!scl) begin
          shift_d = '0;
          cnt_d   = '0;
          phase_d = i2ctrf_pkg::PH_ADDR_H;
        end
      end
      i2ctrf_pkg::PH_ADDR_H: begin
        if (scl) begin
          shift_d = {shift_q[6:0], sda};
          cnt_d   = cnt_inc;
          phase_d = i2ctrf_pkg::PH_ADDR_L;
        end
      end
      i2ctrf_pkg::PH_ADDR_L: begin
        if (!scl) begin
          if (cnt_q < 4'(i2ctrf_pkg::ByteBits)) phase_d = i2ctrf_pkg::PH_ADDR_H;
          else if (shift_q == waddr) phase_d = i2ctrf_pkg::PH_ACK1_H;
          else if (shift_q == raddr) phase_d = i2ctrf_pkg::PH_RACK_H;
          else phase_d = i2ctrf_pkg::PH_IDLE;
        end
      end
      i2ctrf_pkg::PH_ACK1_H: begin
        if (scl) phase_d = i2ctrf_pkg::PH_ACK1_L;
      end
      i2ctrf_pkg::PH_ACK1_L: begin
        if (!scl) begin
          shift_d = '0;
          cnt_d   = '0;
          phase_d = i2ctrf_pkg::PH_REG_H;
        end
      end
      i2ctrf_pkg::PH_REG_H: begin
        if (scl) begin
          shift_d = {shift_q[6:0], sda};
          cnt_d   = cnt_inc;
          phase_d = i2ctrf_pkg::PH_REG_L;
        end
      end
      i2ctrf_pkg::PH_REG_L: begin
        if (!scl) begin
          if (cnt_q < 4'(i2ctrf_pkg::ByteBits)) begin
            phase_d = i2ctrf_pkg::PH_REG_H;
          end else if ({1'b0, shift_q} >= 9'(NUM_REGS)) begin
            phase_d = i2ctrf_pkg::PH_NACK_H;
          end else begin
            ptr_d   = PtrW'(shift_q);
            phase_d = i2ctrf_pkg::PH_ACK2_H;
          end
        end
      end
      i2ctrf_pkg::PH_NACK_H: begin
        if (scl) phase_d = i2ctrf_pkg::PH_NACK_L;
      end
      i2ctrf_pkg::PH_NACK_L: begin
        if (!scl) phase_d = i2ctrf_pkg::PH_IDLE;
      end
      i2ctrf_pkg::PH_ACK2_H: begin
        if (scl) phase_d = i2ctrf_pkg::PH_ACK2_L;
      end
      i2ctrf_pkg::PH_ACK2_L: begin
        if (!scl) begin
          shift_d = '0;
          cnt_d   = '0;
          phase_d = i2ctrf_pkg::PH_D1_H;
        end
      end
      i2ctrf_pkg::PH_D1_H: begin
        if (scl) begin
          shift_d = {shift_q[6:0], sda};
          cnt_d   = cnt_inc;
          phase_d = sda ? i2ctrf_pkg::PH_D1_L_ONE : i2ctrf_pkg::PH_D1_L_ZERO;
        end
      end
      i2ctrf_pkg::PH_D1_L_ONE: begin
        // falling data while the clock is high marks a repeated start
        if (!scl) phase_d = i2ctrf_pkg::PH_DATA_H;
        else if (!sda) phase_d = i2ctrf_pkg::PH_RS_WAIT;
      end
      i2ctrf_pkg::PH_D1_L_ZERO: begin
        if (!scl) phase_d = i2ctrf_pkg::PH_DATA_H;
      end
      i2ctrf_pkg::PH_RS_WAIT: begin
        if (!scl) begin
          shift_d = '0;
          cnt_d   = '0;
          phase_d = i2ctrf_pkg::PH_ADDR_H;
        end
      end
      i2ctrf_pkg::PH_DATA_H: begin
        if (scl) begin
          shift_d = {shift_q[6:0], sda};
          cnt_d   = cnt_inc;
          phase_d = i2ctrf_pkg::PH_DATA_L;
        end
      end
      i2ctrf_pkg::PH_DATA_L: begin
        if (!scl) begin
          phase_d = (cnt_q < 4'(i2ctrf_pkg::ByteBits)) ? i2ctrf_pkg::PH_DATA_H
                                                       : i2ctrf_pkg::PH_ACK3_H;
        end
      end
      i2ctrf_pkg::PH_ACK3_H: begin
        if (scl) begin
          wr_en   = 1'b1;
          phase_d = i2ctrf_pkg::PH_ACK3_L;
        end
      end
      i2ctrf_pkg::PH_ACK3_L: begin
        if (!scl) phase_d = i2ctrf_pkg::PH_IDLE;
      end
      i2ctrf_pkg::PH_RACK_H: begin
        if (scl) begin
          shift_d = rd_q;
          phase_d = i2ctrf_pkg::PH_RACK_L;
        end
      end
      i2ctrf_pkg::PH_RACK_L: begin
        if (!scl) begin
          cnt_d   = '0;
          phase_d = i2ctrf_pkg::PH_TX_H;
        end
      end
      i2ctrf_pkg::PH_TX_H: begin
        if (scl) phase_d = i2ctrf_pkg::PH_TX_L;
      end
      i2ctrf_pkg::PH_TX_L: begin
        if (!scl) begin
          shift_d = {shift_q[6:0], 1'b0};
          cnt_d   = cnt_inc;
          phase_d = (cnt_inc < 4'(i2ctrf_pkg::ByteBits)) ? i2ctrf_pkg::PH_TX_H
                                                         : i2ctrf_pkg::PH_MACK_H;
        end
      end
      i2ctrf_pkg::PH_MACK_H: begin
        if (scl) phase_d = i2ctrf_pkg::PH_MACK_L;
      end
      i2ctrf_pkg::PH_MACK_L: begin
        if (!scl) phase_d = i2ctrf_pkg::PH_IDLE;
      end
      default: begin
        phase_d = i2ctrf_pkg::PH_IDLE;
      end
    endcase
  end

  // result fields from the new phase
  always_comb begin
    res_d = '0;
    if (phase_d inside {i2ctrf_pkg::PH_ACK1_H, i2ctrf_pkg::PH_ACK1_L,
                        i2ctrf_pkg::PH_ACK2_H, i2ctrf_pkg::PH_ACK2_L,
                        i2ctrf_pkg::PH_ACK3_H, i2ctrf_pkg::PH_ACK3_L,
                        i2ctrf_pkg::PH_RACK_H, i2ctrf_pkg::PH_RACK_L}) begin
      res_d.sda_pull_low = 1'b1;
    end else if (phase_d inside {i2ctrf_pkg::PH_TX_H, i2ctrf_pkg::PH_TX_L}) begin
      res_d.sda_pull_low = ((shift_d & i2ctrf_pkg::MsbMask) == '0);
    end
    res_d.store_strobe = wr_en;
    res_d.store_index  = wr_en ? i2ctrf_pkg::IndexW'(ptr_q) : '0;
    res_d.store_value  = wr_en ? shift_q : '0;
    res_d.busy = !(phase_d inside {i2ctrf_pkg::PH_IDLE, i2ctrf_pkg::PH_HIGH,
                                   i2ctrf_pkg::PH_START});
  end

  // control state and written-entry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2ctrf_pkg::PH_IDLE;
      shift_q     <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        shift_q <= shift_d;
        cnt_q   <= cnt_d;
        ptr_q   <= ptr_d;
        if (wr_en) vld_q[ptr_q] <= 1'b1;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

  // register file, unwritten entries read as their own index
  always_ff @(posedge clk_i) begin
    if (step && wr_en) begin
      mem_q[ptr_q] <= shift_q;
    end
    rd_q <= vld_q[ptr_q] ? mem_q[ptr_q] : i2ctrf_pkg::ByteBits'(ptr_q);
  end

endmodule

[verif/tb_i2c_target_register_file.sv]
`timescale 1ns / 1ps

module tb_i2c_target_register_file;

  localparam int unsigned NumRegs = 8;

  // kinds of bus traffic the master can generate
  typedef enum int {
    XF_WRITE,
    XF_REG_READ,
    XF_READ,
    XF_BAD_INDEX,
    XF_OTHER_ADDR,
    XF_STOP_MID,
    XF_NOISE,
    XF_COUNT
  } xfer_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  i2c_target_register_file #(
    .NUM_REGS(NumRegs)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // mirror of the target state
  i2ctrf_pkg::phase_e           tgt_phase;
  logic [3:0]                   tgt_bits;
  logic [7:0]                   tgt_shift;
  logic [i2ctrf_pkg::IndexW-1:0] tgt_ptr;
  logic [7:0]                   tgt_regs [NumRegs];
  logic [6:0]                   tgt_addr;

  i2ctrf_pkg::result_t pending_results [$];
  int unsigned err_count = 0;
  int unsigned sample_count = 0;
  int unsigned xfer_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          bus_wired = 1'b0;
  logic        last_pull = 1'b0;

  function automatic void target_reset();
    for (int i = 0; i < NumRegs; i++) tgt_regs[i] = 8'(i);
    tgt_phase = i2ctrf_pkg::PH_IDLE;
    tgt_bits  = '0;
    tgt_shift = '0;
    tgt_ptr   = '0;
    tgt_addr  = 7'd32;
  endfunction

  function automatic bit target_busy();
    return !(tgt_phase inside {i2ctrf_pkg::PH_IDLE, i2ctrf_pkg::PH_HIGH,
                               i2ctrf_pkg::PH_START});
  endfunction

  function automatic void open_byte(input i2ctrf_pkg::phase_e nxt);
    tgt_shift = '0;
    tgt_bits  = '0;
    tgt_phase = nxt;
  endfunction

  function automatic void take_bit(input logic sda, input i2ctrf_pkg::phase_e nxt);
    tgt_shift = {tgt_shift[6:0], sda};
    tgt_bits  = tgt_bits + 4'd1;
    tgt_phase = nxt;
  endfunction

  // advance the mirror by one line sample and give the expected response
  function automatic i2ctrf_pkg::result_t predict_sample(input logic scl, input logic sda);
    i2ctrf_pkg::result_t r;
    logic [7:0]          waddr;
    r = '0;
    waddr = {tgt_addr, 1'b0};
    case (tgt_phase)
      i2ctrf_pkg::PH_IDLE: if (scl && sda) tgt_phase = i2ctrf_pkg::PH_HIGH;
      i2ctrf_pkg::PH_HIGH: begin
        if (!scl) tgt_phase = i2ctrf_pkg::PH_IDLE;
        else if (!sda) tgt_phase = i2ctrf_pkg::PH_START;
      end
      i2ctrf_pkg::PH_START: begin
        if (sda) begin
          if (scl) tgt_phase = i2ctrf_pkg::PH_HIGH;
          else tgt_phase = i2ctrf_pkg::PH_IDLE;
        end else if (!scl) begin
          open_byte(i2ctrf_pkg::PH_ADDR_H);
        end
      end
      i2ctrf_pkg::PH_ADDR_H: if (scl) take_bit(sda, i2ctrf_pkg::PH_ADDR_L);
      i2ctrf_pkg::PH_ADDR_L: begin
        if (!scl) begin
          if (tgt_bits < i2ctrf_pkg::ByteBits) tgt_phase = i2ctrf_pkg::PH_ADDR_H;
          else if (tgt_shift == waddr) tgt_phase = i2ctrf_pkg::PH_ACK1_H;
          else if (tgt_shift == (waddr | 8'd1)) tgt_phase = i2ctrf_pkg::PH_RACK_H;
          else tgt_phase = i2ctrf_pkg::PH_IDLE;
        end
      end
      i2ctrf_pkg::PH_ACK1_H: if (scl) tgt_phase = i2ctrf_pkg::PH_ACK1_L;
      i2ctrf_pkg::PH_ACK1_L: if (!scl) open_byte(i2ctrf_pkg::PH_REG_H);
      i2ctrf_pkg::PH_REG_H: if (scl) take_bit(sda, i2ctrf_pkg::PH_REG_L);
      i2ctrf_pkg::PH_REG_L: begin
        if (!scl) begin
          if (tgt_bits < i2ctrf_pkg::ByteBits) begin
            tgt_phase = i2ctrf_pkg::PH_REG_H;
          end else if (tgt_shift >= NumRegs) begin
            tgt_phase = i2ctrf_pkg::PH_NACK_H;
          end else begin
            tgt_ptr   = tgt_shift[i2ctrf_pkg::IndexW-1:0];
            tgt_phase = i2ctrf_pkg::PH_ACK2_H;
          end
        end
      end
      i2ctrf_pkg::PH_NACK_H: if (scl) tgt_phase = i2ctrf_pkg::PH_NACK_L;
      i2ctrf_pkg::PH_NACK_L: if (!scl) tgt_phase = i2ctrf_pkg::PH_IDLE;
      i2ctrf_pkg::PH_ACK2_H: if (scl) tgt_phase = i2ctrf_pkg::PH_ACK2_L;
      i2ctrf_pkg::PH_ACK2_L: if (!scl) open_byte(i2ctrf_pkg::PH_D1_H);
      i2ctrf_pkg::PH_D1_H: begin
        if (scl) begin
          if (sda) take_bit(sda, i2ctrf_pkg::PH_D1_L_ONE);
          else take_bit(sda, i2ctrf_pkg::PH_D1_L_ZERO);
        end
      end
      i2ctrf_pkg::PH_D1_L_ONE: begin
        if (!scl) tgt_phase = i2ctrf_pkg::PH_DATA_H;
        else if (!sda) tgt_phase = i2ctrf_pkg::PH_RS_WAIT;
      end
      i2ctrf_pkg::PH_D1_L_ZERO: if (!scl) tgt_phase = i2ctrf_pkg::PH_DATA_H;
      i2ctrf_pkg::PH_RS_WAIT: if (!scl) open_byte(i2ctrf_pkg::PH_ADDR_H);
      i2ctrf_pkg::PH_DATA_H: if (scl) take_bit(sda, i2ctrf_pkg::PH_DATA_L);
      i2ctrf_pkg::PH_DATA_L: begin
        if (!scl) begin
          if (tgt_bits < i2ctrf_pkg::ByteBits) tgt_phase = i2ctrf_pkg::PH_DATA_H;
          else tgt_phase = i2ctrf_pkg::PH_ACK3_H;
        end
      end
      i2ctrf_pkg::PH_ACK3_H: begin
        if (scl) begin
          tgt_regs[tgt_ptr] = tgt_shift;
          r.store_strobe = 1'b1;
          r.store_index  = tgt_ptr;
          r.store_value  = tgt_shift;
          tgt_phase      = i2ctrf_pkg::PH_ACK3_L;
        end
      end
      i2ctrf_pkg::PH_ACK3_L: if (!scl) tgt_phase = i2ctrf_pkg::PH_IDLE;
      i2ctrf_pkg::PH_RACK_H: begin
        if (scl) begin
          tgt_shift = tgt_regs[tgt_ptr];
          tgt_phase = i2ctrf_pkg::PH_RACK_L;
        end
      end
      i2ctrf_pkg::PH_RACK_L: begin
        if (!scl) begin
          tgt_bits  = '0;
          tgt_phase = i2ctrf_pkg::PH_TX_H;
        end
      end
      i2ctrf_pkg::PH_TX_H: if (scl) tgt_phase = i2ctrf_pkg::PH_TX_L;
      i2ctrf_pkg::PH_TX_L: begin
        if (!scl) begin
          tgt_shift = tgt_shift << 1;
          tgt_bits  = tgt_bits + 4'd1;
          if (tgt_bits < i2ctrf_pkg::ByteBits) tgt_phase = i2ctrf_pkg::PH_TX_H;
          else tgt_phase = i2ctrf_pkg::PH_MACK_H;
        end
      end
      i2ctrf_pkg::PH_MACK_H: if (scl) tgt_phase = i2ctrf_pkg::PH_MACK_L;
      i2ctrf_pkg::PH_MACK_L: if (!scl) tgt_phase = i2ctrf_pkg::PH_IDLE;
      default: tgt_phase = i2ctrf_pkg::PH_IDLE;
    endcase

    // open-drain drive after the sample
    case (tgt_phase)
      i2ctrf_pkg::PH_ACK1_H, i2ctrf_pkg::PH_ACK1_L, i2ctrf_pkg::PH_ACK2_H,
      i2ctrf_pkg::PH_ACK2_L, i2ctrf_pkg::PH_ACK3_H, i2ctrf_pkg::PH_ACK3_L,
      i2ctrf_pkg::PH_RACK_H, i2ctrf_pkg::PH_RACK_L: r.sda_pull_low = 1'b1;
      i2ctrf_pkg::PH_TX_H, i2ctrf_pkg::PH_TX_L:
        r.sda_pull_low = ((tgt_shift & i2ctrf_pkg::MsbMask) == 8'h00);
      default: r.sda_pull_low = 1'b0;
    endcase
    r.busy = target_busy();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    err_count++;
  endtask

  // send one line sample as a request, wired-and with the target drive if asked
  task automatic send_sample(input logic scl, input logic sda);
    logic                line_sda;
    i2ctrf_pkg::result_t want;
    bit                  rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    line_sda = sda & ~(bus_wired & last_pull);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, line_sda, scl};
    want = predict_sample(scl, line_sda);
    last_pull = want.sda_pull_low;
    pending_results.push_back(want);
    sample_count++;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // hold off the sender until every response is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic bus_bit(input logic b);
    repeat ($urandom_range(1, 2)) send_sample(1'b0, b);
    repeat ($urandom_range(1, 2)) send_sample(1'b1, b);
  endtask

  task automatic bus_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) bus_bit(v[i]);
  endtask

  task automatic bus_start();
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
  endtask

  task automatic bus_stop();
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  // clock released bits until the target is back at the start wait
  task automatic bus_release();
    bus_wired = 1'b0;
    while (target_busy()) begin
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
    end
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic xfer_e pick_xfer();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return XF_WRITE;
    if (r < 60) return XF_REG_READ;
    if (r < 72) return XF_READ;
    if (r < 80) return XF_BAD_INDEX;
    if (r < 87) return XF_OTHER_ADDR;
    if (r < 93) return XF_STOP_MID;
    return XF_NOISE;
  endfunction

  // one master transaction with random content
  task automatic run_xfer(input xfer_e kind);
    logic [6:0] peer;
    bus_release();
    bus_wired = ($urandom_range(3) != 0);
    repeat ($urandom_range(1, 3)) send_sample(1'b1, 1'b1);
    bus_start();
    case (kind)
      XF_WRITE: begin
        bus_byte({tgt_addr, 1'b0});
        bus_bit(1'b1);
        bus_byte(8'($urandom_range(NumRegs - 1)));
        bus_bit(1'b1);
        bus_byte(pick_data());
        bus_bit(1'b1);
        bus_stop();
      end
      XF_REG_READ: begin
        bus_byte({tgt_addr, 1'b0});
        bus_bit(1'b1);
        bus_byte(8'($urandom_range(NumRegs - 1)));
        bus_bit(1'b1);
        // repeated start inside the first data bit
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        bus_byte({tgt_addr, 1'b1});
        bus_bit(1'b1);
        repeat (8) bus_bit(1'b1);
        bus_bit(1'($urandom_range(1)));
        bus_stop();
      end
      XF_READ: begin
        bus_byte({tgt_addr, 1'b1});
        bus_bit(1'b1);
        repeat (8) bus_bit(1'b1);
        bus_bit(1'($urandom_range(1)));
        bus_stop();
      end
      XF_BAD_INDEX: begin
        bus_byte({tgt_addr, 1'b0});
        bus_bit(1'b1);
        if ($urandom_range(1)) bus_byte(8'($urandom_range(255, NumRegs)));
        else bus_byte(8'hff);
        bus_bit(1'b1);
        bus_stop();
      end
      XF_OTHER_ADDR: begin
        peer = 7'($urandom_range(127));
        if (peer == tgt_addr) peer = peer ^ 7'h01;
        bus_byte({peer, 1'($urandom_range(1))});
        repeat ($urandom_range(1, 4)) bus_bit(1'($urandom_range(1)));
        bus_stop();
      end
      XF_STOP_MID: begin
        bus_byte({tgt_addr, 1'b0});
        bus_bit(1'b1);
        repeat ($urandom_range(1, 7)) bus_bit(1'($urandom_range(1)));
        // a stop and start here are only clocked bits to the target
        bus_stop();
        bus_start();
      end
      default: begin
        repeat ($urandom_range(1, 12)) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    endcase
  endtask

  // line extremes and aborted start conditions
  task automatic test_line_levels();
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
    // sda rises again while scl stays high
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    // sda rises after scl went low
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    // scl falls before sda
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    // both fall together
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    // a proper start, then a short run of clocks
    bus_start();
    repeat (3) bus_bit(1'b1);
    bus_release();
  endtask

  // random bus traffic under one address and one pacing setting
  task automatic test_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int addr, input int unsigned n_items);
    int unsigned stop_at;
    xfer_e       kind;
    wait_drained();
    if (addr >= 0) begin
      cfg_wdata_i <= 7'(addr);
      cfg_we_i    <= 1'b1;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      tgt_addr = 7'(addr);
    end
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = sample_count + n_items;
    while (sample_count < stop_at) begin
      if (xfer_count < XF_COUNT) kind = xfer_e'(xfer_count);
      else kind = pick_xfer();
      if ($urandom_range(9) == 0) wait_drained();
      run_xfer(kind);
      xfer_count++;
    end
  endtask

  // receiver side: check each accepted response against the oldest prediction
  bit          out_hs = 1'b0;
  logic [15:0] out_word = '0;

  always @(negedge clk_i) begin
    out_hs   = rst_ni && m_axis_tvalid && m_axis_tready;
    out_word = m_axis_tdata;
  end

  always @(posedge clk_i) begin
    i2ctrf_pkg::result_t got;
    i2ctrf_pkg::result_t want;
    if (out_hs) begin
      got = i2ctrf_pkg::result_t'(out_word[13:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected response", int'(out_word), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.sda_pull_low !== want.sda_pull_low)
          report_mismatch("sda_pull_low", got.sda_pull_low, want.sda_pull_low);
        if (got.store_strobe !== want.store_strobe)
          report_mismatch("store_strobe", got.store_strobe, want.store_strobe);
        if (got.store_index !== want.store_index)
          report_mismatch("store_index", got.store_index, want.store_index);
        if (got.store_value !== want.store_value)
          report_mismatch("store_value", got.store_value, want.store_value);
        if (got.busy !== want.busy)
          report_mismatch("busy_res", got.busy, want.busy);
        if (out_word[15:14] !== 2'b00)
          report_mismatch("zero fill", out_word[15:14], 0);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // main sequence
  initial begin
    target_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_line_levels();
    test_traffic(0, 0, -1, 120);
    test_traffic(61, 0, 0, 120);
    test_traffic(0, 61, 127, 120);
    test_traffic(7, 7, $urandom_range(127), 120);
    bus_release();
    wait_drained();
    if (err_count == 0) begin
      $display("tb_i2c_target_register_file passed");
    end else begin
      $display("tb_i2c_target_register_file failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_i2c_target_register_file failed");
    $finish;
  end

endmodule
